// ===== sv/idwr_pkg.sv =====
// Shared definitions for the integer divider with remainder.
// Holds the default data width and the sequencer state encoding.
// No dependencies.
package idwr_pkg;

	parameter int unsigned IDWR_WIDTH = 32;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIX  = 3'b100
	} idwr_state_t;

endpackage

// ===== sv/idwr_step.sv =====
// One restoring division step: shift in a dividend bit, trial subtract, restore on borrow.
// Used once per cycle by the divider sequencer. Depends on idwr_pkg.
module idwr_step #(
	parameter int unsigned WIDTH = idwr_pkg::IDWR_WIDTH
) (
	input  logic [WIDTH-1:0] rem_in,
	input  logic             msb_in,
	input  logic [WIDTH-1:0] den,
	output logic [WIDTH-1:0] rem_out,
	output logic             qbit
);
	import idwr_pkg::*;

	logic [WIDTH:0] shifted;
	logic [WIDTH:0] trial;

	assign shifted = {rem_in, msb_in};
	assign trial   = shifted - {1'b0, den};
	assign qbit    = ~trial[WIDTH];
	assign rem_out = qbit ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];

endmodule

// ===== sv/integer_divide_with_remainder.sv =====
// Integer divider with remainder, unsigned or signed, built round one shared subtract unit.
// Top level: operand preparation, bit-serial sequencer, sign fix-up and output register.
// Depends on idwr_pkg and idwr_step.
//
// Each item runs through the sequencer after its transfer: one quotient bit is produced per
// cycle by the single restoring subtract unit, followed by sign correction, which registers the
// result. The sequencer then returns to idle; it takes no new item until the current one has
// passed sign correction. Sign correction waits while the previous result is still stalled in the
// output register, which holds back the result and the return to idle. A new item is accepted
// as soon as the sequencer is idle, even while the previous result still waits in the output
// register. Signed mode truncates towards zero and the remainder takes the sign of the dividend.
// A zero divisor gives a zero quotient and returns the dividend as the remainder.
module integer_divide_with_remainder #(
	parameter int unsigned WIDTH = idwr_pkg::IDWR_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             func,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WIDTH-1:0] quotient,
	output logic [WIDTH-1:0] remainder
);
	import idwr_pkg::*;

	localparam int unsigned CNT_W = $clog2(WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

	idwr_state_t      state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] den_q;
	logic             qneg_q;
	logic             rneg_q;
	logic             zero_q;
	logic             out_valid_q;
	logic [WIDTH-1:0] quotient_q;
	logic [WIDTH-1:0] remainder_q;

	logic             in_xfer;
	logic             out_free;
	logic             a_neg;
	logic             b_neg;
	logic [WIDTH-1:0] mag_a;
	logic [WIDTH-1:0] mag_b;
	logic [WIDTH-1:0] step_rem;
	logic             step_qbit;
	logic [WIDTH-1:0] q_mag;
	logic [WIDTH-1:0] q_fix;
	logic [WIDTH-1:0] r_fix;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign a_neg = func && dividend[WIDTH-1];
	assign b_neg = func && divisor[WIDTH-1];
	assign mag_a = a_neg ? (~dividend + WIDTH'(1)) : dividend;
	assign mag_b = b_neg ? (~divisor + WIDTH'(1)) : divisor;

	idwr_step #(
		.WIDTH(WIDTH)
	) u_step (
		.rem_in (rem_q),
		.msb_in (acc_q[WIDTH-1]),
		.den    (den_q),
		.rem_out(step_rem),
		.qbit   (step_qbit)
	);

	// With a zero divisor every trial subtraction succeeds, so the remainder collects the
	// dividend magnitude unchanged and only the quotient needs forcing to zero.
	assign q_mag = zero_q ? '0 : acc_q;
	assign q_fix = qneg_q ? (~q_mag + WIDTH'(1)) : q_mag;
	assign r_fix = rneg_q ? (~rem_q + WIDTH'(1)) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_RUN;
						cnt_q   <= CNT_LAST;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_FIX && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rem_q  <= '0;
			acc_q  <= mag_a;
			den_q  <= mag_b;
			qneg_q <= a_neg ^ b_neg;
			rneg_q <= a_neg;
			zero_q <= (divisor == '0);
		end else if (state_q == ST_RUN) begin
			rem_q <= step_rem;
			acc_q <= {acc_q[WIDTH-2:0], step_qbit};
		end
		if (state_q == ST_FIX && out_free) begin
			quotient_q  <= q_fix;
			remainder_q <= r_fix;
		end
	end

	assign out_valid = out_valid_q;
	assign quotient  = quotient_q;
	assign remainder = remainder_q;

`ifndef SYNTH
	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_RUN && cnt_q == CNT_LAST))
		else $error("accepted transfer did not start the iteration");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && cnt_q == '0) |=> (state_q == ST_FIX))
		else $error("iteration did not finish into sign fix-up");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIX))
		else $error("result presented without a completed division");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for integer_divide_with_remainder: drives operand transfers with random gaps
// and collects results under random stalls, checking each against a local divider prediction.
// Depends on idwr_pkg and the integer_divide_with_remainder RTL.
module tb;

	localparam int unsigned W = idwr_pkg::IDWR_WIDTH;
	localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
	localparam int unsigned NUM_RANDOM = 1150;

	typedef struct packed {
		logic [W-1:0] quotient;
		logic [W-1:0] remainder;
	} div_result_t;

	class divide_scoreboard;
		div_result_t expected_results[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function void note_operands(logic is_signed, logic [W-1:0] num, logic [W-1:0] den);
			logic [W-1:0] num_mag;
			logic [W-1:0] den_mag;
			logic [W-1:0] quo;
			logic flip;
			div_result_t res;
			num_mag = num;
			den_mag = den;
			flip = 1'b0;
			if (is_signed) begin
				if (num[W-1]) begin
					num_mag = -num;
					flip = ~flip;
				end
				if (den[W-1]) begin
					den_mag = -den;
					flip = ~flip;
				end
			end
			quo = (den_mag == '0) ? '0 : num_mag / den_mag;
			if (flip)
				quo = -quo;
			res.quotient = quo;
			res.remainder = num - quo * den;
			expected_results.push_back(res);
		endfunction

		function void check_result(logic [W-1:0] quo, logic [W-1:0] rem);
			div_result_t exp_res;
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected: quotient %h remainder %h", quo, rem);
				errors++;
				return;
			end
			exp_res = expected_results.pop_front();
			if (quo !== exp_res.quotient) begin
				$error("quotient: expected %h, actual %h", exp_res.quotient, quo);
				errors++;
			end
			if (rem !== exp_res.remainder) begin
				$error("remainder: expected %h, actual %h", exp_res.remainder, rem);
				errors++;
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic func;
	logic [W-1:0] dividend;
	logic [W-1:0] divisor;
	logic out_valid;
	logic out_stall;
	logic [W-1:0] quotient;
	logic [W-1:0] remainder;
	bit quiet;

	divide_scoreboard sb = new();

	integer_divide_with_remainder #(.WIDTH(W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.dividend(dividend),
		.divisor(divisor),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.quotient(quotient),
		.remainder(remainder)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_operands(input logic is_signed, input logic [W-1:0] num,
			input logic [W-1:0] den);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		func = is_signed;
		dividend = num;
		divisor = den;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_operands(is_signed, num, den);
		@(negedge clk);
	endtask

	function automatic logic [W-1:0] pick_operand();
		logic [W-1:0] v;
		v = $urandom;
		case ($urandom_range(0, 6))
			0, 1: ;
			2: v = $urandom_range(0, 15);
			3: v = v >> $urandom_range(1, W - 1);
			4: v = -W'($urandom_range(1, 16));
			5: begin
				case ($urandom_range(0, 4))
					0: v = '0;
					1: v = W'(1);
					2: v = ALL_ONES;
					3: v = MOST_NEG;
					default: v = MOST_POS;
				endcase
			end
			default: v = ~(v >> $urandom_range(1, W - 1));
		endcase
		return v;
	endfunction

	initial begin : result_sink
		int hold;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			hold = quiet ? 0 : $urandom_range(0, 12);
			if (hold > 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			sb.check_result(quotient, remainder);
		end
	end

	initial begin : stimulus
		logic [W-1:0] dir_num[12];
		logic [W-1:0] dir_den[12];
		dir_num = '{W'(0), W'(5), ALL_ONES, MOST_NEG, ALL_ONES, W'(7), -W'(7), -W'(7),
			MOST_NEG, MOST_POS, MOST_NEG, W'(1)};
		dir_den = '{W'(0), W'(0), W'(0), ALL_ONES, W'(1), -W'(2), W'(2), -W'(2),
			MOST_NEG, MOST_NEG, W'(1), ALL_ONES};
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = 1'b0;
		dividend = '0;
		divisor = '0;
		quiet = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		for (int m = 0; m < 2; m++)
			for (int k = 0; k < 12; k++)
				send_operands(m[0], dir_num[k], dir_den[k]);
		for (int i = 0; i < NUM_RANDOM; i++) begin
			quiet = ((i / 150) % 4) == 3;
			send_operands($urandom_range(0, 1), pick_operand(), pick_operand());
		end
		in_valid = 1'b0;
		quiet = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3 * (W + 2)) @(posedge clk);
		if (sb.errors == 0)
			$display("integer_divide_with_remainder: match");
		else
			$display("integer_divide_with_remainder: mismatch");
		$finish;
	end

	initial begin : watchdog
		#4000000;
		$display("integer_divide_with_remainder: mismatch");
		$finish;
	end

endmodule
